>>> hw/rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants for the generational slot allocator
// Operation and status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int GEN_BITS_DEF   = 16;

  localparam int OP_W        = 3;
  localparam int GEN_FIELD_W = 16;
  localparam int VER_W       = 16;
  localparam int LAYOUT_W    = 4;
  localparam int STATUS_W    = 2;

  localparam logic [VER_W-1:0] VER_MAX = {VER_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CREATE     = 3'd0,
    OP_DESTROY    = 3'd1,
    OP_RECREATE   = 3'd2,
    OP_QUERY      = 3'd3,
    OP_TRANSITION = 3'd4,
    OP_CHECK      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_TAKE = 2'd2
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator: handle table with generation counters
// Create, destroy, recreate, query, layout transition and layout check on
// (index, generation) handles, with a LIFO free stack of released slots.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, and the receiver
// cannot stall it. Destroy, query, transition, check, a rejected request and a
// create that takes a never-used slot finish with done high in the cycle
// after the memory read returns, in which the next start is already taken.
// A create or recreate that pops the free stack also passes through S_TAKE: the popped
// index needs a second read of the slot memory, which has one read port.
// Slot state lives in one synchronous RAM and the free stack in another. The
// count of slots ever used doubles as the fill mark of the slot memory, so
// no clearing pass is needed after reset.
`default_nettype none

module generational_slot_allocator #(
  parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [gsa_pkg::OP_W-1:0]          op,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]     slot_index,
  input  wire logic [gsa_pkg::GEN_FIELD_W-1:0]   slot_generation,
  input  wire logic [gsa_pkg::LAYOUT_W-1:0]      layout_code,
  output logic                                   done,
  output logic      [gsa_pkg::STATUS_W-1:0]      status,
  output logic      [$clog2(SLOT_COUNT)-1:0]     result_index,
  output logic      [gsa_pkg::GEN_FIELD_W-1:0]   result_generation,
  output logic      [gsa_pkg::VER_W-1:0]         result_version,
  output logic      [gsa_pkg::LAYOUT_W-1:0]      old_layout,
  output logic                                   layout_match
);

  import gsa_pkg::*;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int ENTRY_W = 1 + LAYOUT_W + VER_W + GEN_BITS;
  localparam int CMP_W   = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;
  localparam logic [CMP_W-1:0] GEN_MASK = CMP_W'((64'd1 << GEN_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(SLOT_COUNT);

  state_t state, state_next;

  // captured transaction
  logic [OP_W-1:0]        op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [GEN_FIELD_W-1:0] gen_q;
  logic [LAYOUT_W-1:0]    lay_q;

  logic [CNT_W-1:0] free_count, free_count_next;
  logic [CNT_W-1:0] slots_used, slots_used_next;
  logic [IDX_W-1:0] take_idx, take_idx_next;

  // slot memory: {active, layout, version, generation}
  logic               slot_we;
  logic [IDX_W-1:0]   slot_waddr, slot_raddr;
  logic [ENTRY_W-1:0] slot_wdata, slot_rdata;

  logic               stk_we;
  logic [IDX_W-1:0]   stk_waddr, stk_raddr;
  logic [IDX_W-1:0]   stk_wdata, stk_rdata;

  logic                e_act;
  logic [LAYOUT_W-1:0] e_lay;
  logic [VER_W-1:0]    e_ver;
  logic [GEN_BITS-1:0] e_gen, gen_inc;
  logic [VER_W-1:0]    ver_inc;
  logic                valid, take_pop;

  logic                   done_next;
  status_t                res_status;
  logic [IDX_W-1:0]       res_idx;
  logic [GEN_FIELD_W-1:0] res_gen;
  logic [VER_W-1:0]       res_ver;
  logic [LAYOUT_W-1:0]    res_old;
  logic                   res_match;

  gsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign busy = (state != S_IDLE);

  // second slot read goes to the popped index
  assign slot_raddr = (state == S_IDLE) ? slot_index : stk_rdata;
  assign stk_raddr  = IDX_W'(free_count - CNT_W'(1));

  assign e_gen = slot_rdata[GEN_BITS-1:0];
  assign e_ver = slot_rdata[GEN_BITS +: VER_W];
  assign e_lay = slot_rdata[GEN_BITS + VER_W +: LAYOUT_W];
  assign e_act = slot_rdata[ENTRY_W-1];

  assign gen_inc = e_gen + GEN_BITS'(1);
  assign ver_inc = (e_ver == VER_MAX) ? VER_MAX : e_ver + VER_W'(1);

  // entries at or above slots_used were never written: gated here
  assign valid = (CNT_W'(idx_q) < slots_used) && e_act &&
                 (CMP_W'(e_gen) == (CMP_W'(gen_q) & GEN_MASK));

  assign take_pop = ((op_q == OP_CREATE) || ((op_q == OP_RECREATE) && !valid)) &&
                    (free_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      slots_used <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      slots_used <= slots_used_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q  <= op;
      idx_q <= slot_index;
      gen_q <= slot_generation;
      lay_q <= layout_code;
    end
    take_idx <= take_idx_next;
    if (done_next) begin
      status            <= res_status;
      result_index      <= res_idx;
      result_generation <= res_gen;
      result_version    <= res_ver;
      old_layout        <= res_old;
      layout_match      <= res_match;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = take_pop ? S_TAKE : S_IDLE;
      end
      S_TAKE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    slot_we         = 1'b0;
    slot_waddr      = idx_q;
    slot_wdata      = '0;
    stk_we          = 1'b0;
    stk_waddr       = IDX_W'(free_count);
    stk_wdata       = idx_q;
    free_count_next = free_count;
    slots_used_next = slots_used;
    take_idx_next   = take_idx;
    done_next       = 1'b0;
    res_status      = ST_OK;
    res_idx         = '0;
    res_gen         = '0;
    res_ver         = '0;
    res_old         = '0;
    res_match       = 1'b0;
    case (state)
      S_EXEC: begin
        case (op_t'(op_q))
          OP_CREATE, OP_RECREATE: begin
            if (op_q == OP_RECREATE && valid) begin
              // release and immediate re-take of the same slot: stack unchanged
              done_next  = 1'b1;
              slot_we    = 1'b1;
              slot_wdata = {1'b1, LAYOUT_W'(0), ver_inc, gen_inc};
              res_idx    = idx_q;
              res_gen    = GEN_FIELD_W'(gen_inc);
              res_ver    = ver_inc;
            end else if (take_pop) begin
              free_count_next = free_count - CNT_W'(1);
              take_idx_next   = stk_rdata;
            end else if (slots_used < SLOTS_MAX) begin
              done_next       = 1'b1;
              slot_we         = 1'b1;
              slot_waddr      = IDX_W'(slots_used);
              slot_wdata      = {1'b1, LAYOUT_W'(0), VER_W'(1), GEN_BITS'(0)};
              slots_used_next = slots_used + CNT_W'(1);
              res_idx         = IDX_W'(slots_used);
              res_ver         = VER_W'(1);
            end else begin
              done_next  = 1'b1;
              res_status = ST_FULL;
            end
          end
          OP_DESTROY: begin
            done_next = 1'b1;
            if (valid) begin
              slot_we    = 1'b1;
              slot_wdata = {1'b0, LAYOUT_W'(0), e_ver, gen_inc};
              if (free_count < SLOTS_MAX) begin
                stk_we          = 1'b1;
                free_count_next = free_count + CNT_W'(1);
              end
            end else begin
              res_status = ST_INVALID;
            end
          end
          OP_QUERY, OP_TRANSITION, OP_CHECK: begin
            done_next = 1'b1;
            if (valid) begin
              res_idx = idx_q;
              res_gen = GEN_FIELD_W'(e_gen);
              res_ver = e_ver;
              res_old = e_lay;
              if (op_q == OP_TRANSITION) begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, lay_q, e_ver, e_gen};
              end else begin
                res_match = (e_lay == lay_q);
              end
            end else begin
              res_status = ST_INVALID;
            end
          end
          default: begin
            done_next  = 1'b1;
            res_status = ST_INVALID;
          end
        endcase
      end
      S_TAKE: begin
        // slot_rdata now holds the popped slot
        done_next  = 1'b1;
        slot_we    = 1'b1;
        slot_waddr = take_idx;
        slot_wdata = {1'b1, LAYOUT_W'(0), VER_W'(1), e_gen};
        res_idx    = take_idx;
        res_gen    = GEN_FIELD_W'(e_gen);
        res_ver    = VER_W'(1);
      end
      default: begin
      end
    endcase
  end

  a_done_from_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EXEC || $past(state) == S_TAKE))
    else $error("done without a finishing state");

  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_count <= slots_used)
    else $error("free stack deeper than slots ever used");

  a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (free_count == '0 && slots_used == SLOTS_MAX))
    else $error("table full reported with slots left");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");

endmodule

`default_nettype wire

>>> hw/rtl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> tb/sv/gsa_check_pkg.sv
// ----------------------------------------------------------------------------
// gsa_check_pkg: handle table scoreboard for the slot allocator bench
// Mirrors the slot table (active bits, generations, layouts, versions, free
// stack) and predicts the reply of every accepted transaction, then compares
// each reply from the block field by field against the oldest prediction.
// ----------------------------------------------------------------------------
package gsa_check_pkg;

  import gsa_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int IDX_W = $clog2(SLOTS);

  // ops the block does not define
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    status_t                 status;
    logic [IDX_W-1:0]        index;
    logic [GEN_FIELD_W-1:0]  generation;
    logic [VER_W-1:0]        version;
    logic [LAYOUT_W-1:0]     old_layout;
    logic                    layout_match;
  } slot_reply_t;

  class slot_table_scoreboard;

    bit                     active [SLOTS];
    logic [GEN_FIELD_W-1:0] gen_store [SLOTS];
    logic [LAYOUT_W-1:0]    layout_store [SLOTS];
    logic [VER_W-1:0]       version_store [SLOTS];
    int unsigned            free_stack [SLOTS];
    int unsigned            free_count;
    int unsigned            slots_used;

    slot_reply_t            expected_replies [$];
    int                     errors;
    int                     op_count [8];
    int                     replies_checked;
    int                     full_seen;
    int                     invalid_seen;

    function new();
      foreach (active[i]) begin
        active[i]        = 1'b0;
        gen_store[i]     = '0;
        layout_store[i]  = '0;
        version_store[i] = '0;
        free_stack[i]    = 0;
      end
      foreach (op_count[i]) op_count[i] = 0;
      free_count      = 0;
      slots_used      = 0;
      errors          = 0;
      replies_checked = 0;
      full_seen       = 0;
      invalid_seen    = 0;
    endfunction

    function bit handle_live(int unsigned idx, logic [GEN_FIELD_W-1:0] gen);
      return idx < slots_used && active[idx] && gen_store[idx] == gen;
    endfunction

    function void free_slot(int unsigned idx);
      active[idx]       = 1'b0;
      gen_store[idx]    = gen_store[idx] + 1'b1;  // wraps at GEN_BITS = 16
      layout_store[idx] = '0;
      if (free_count < SLOTS) begin
        free_stack[free_count] = idx;
        free_count++;
      end
    endfunction

    // LIFO pop first, then a never-used slot
    function bit grab_slot(output int unsigned k);
      if (free_count > 0) begin
        free_count--;
        k = free_stack[free_count];
      end else if (slots_used < SLOTS) begin
        k = slots_used;
        slots_used++;
      end else begin
        k = 0;
        return 1'b0;
      end
      active[k]        = 1'b1;
      layout_store[k]  = '0;
      version_store[k] = VER_W'(1);
      return 1'b1;
    endfunction

    function void note_request(logic [OP_W-1:0] op_bits, logic [IDX_W-1:0] idx,
                               logic [GEN_FIELD_W-1:0] gen, logic [LAYOUT_W-1:0] lay);
      slot_reply_t      r;
      logic [VER_W-1:0] ver;
      int unsigned      k;
      bit               live;
      r    = '0;
      live = handle_live(idx, gen);
      op_count[op_bits]++;
      case (op_bits)
        OP_CREATE, OP_RECREATE: begin
          ver = VER_W'(1);
          if (op_bits == OP_RECREATE && live) begin
            ver = (version_store[idx] == VER_MAX) ? VER_MAX : version_store[idx] + 1'b1;
            free_slot(idx);
          end
          if (grab_slot(k)) begin
            version_store[k] = ver;
            r.index          = k[IDX_W-1:0];
            r.generation     = gen_store[k];
            r.version        = ver;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_DESTROY: begin
          if (live) free_slot(idx);
          else r.status = ST_INVALID;
        end
        OP_QUERY, OP_TRANSITION, OP_CHECK: begin
          if (!live) begin
            r.status = ST_INVALID;
          end else begin
            r.index      = idx;
            r.generation = gen_store[idx];
            r.version    = version_store[idx];
            r.old_layout = layout_store[idx];
            if (op_bits == OP_TRANSITION) layout_store[idx] = lay;
            else r.layout_match = (layout_store[idx] == lay);
          end
        end
        default: r.status = ST_INVALID;
      endcase
      if (r.status == ST_FULL) full_seen++;
      if (r.status == ST_INVALID) invalid_seen++;
      expected_replies = {expected_replies, r};
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got,
                                longint unsigned now);
      if (want != got) begin
        errors++;
        $display("t=%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", now, name, want, got);
      end
    endfunction

    function void check_reply(slot_reply_t got, longint unsigned now);
      slot_reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("t=%0d ns: reply with no transaction pending (status 0x%0h)", now,
                 got.status);
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      compare_field("status", want.status, got.status, now);
      compare_field("result_index", want.index, got.index, now);
      compare_field("result_generation", want.generation, got.generation, now);
      compare_field("result_version", want.version, got.version, now);
      compare_field("old_layout", want.old_layout, got.old_layout, now);
      compare_field("layout_match", want.layout_match, got.layout_match, now);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function bit pick_live(output int unsigned idx, output logic [GEN_FIELD_W-1:0] gen);
      int unsigned live_slots [$];
      for (int unsigned i = 0; i < slots_used; i++)
        if (active[i]) live_slots = {live_slots, i};
      idx = 0;
      gen = '0;
      if (live_slots.size() == 0) return 1'b0;
      idx = live_slots[$urandom_range(live_slots.size() - 1)];
      gen = gen_store[idx];
      return 1'b1;
    endfunction

  endclass

endpackage

>>> tb/sv/generational_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator_test: self-checking bench for the slot allocator
// Directed handle cases, random transactions with idle gaps that include a
// table fill to the full condition, then a back-to-back run recycling one slot.
// Every reply is checked by the scoreboard.
// ----------------------------------------------------------------------------
module generational_slot_allocator_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;
  import gsa_check_pkg::*;

  localparam int RANDOM_ITEMS   = 620;
  localparam int RECYCLE_ROUNDS = 40;  // back-to-back stretch, no idle cycles
  localparam int CYCLE_LIMIT    = 1000000;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [OP_W-1:0]        op;
  logic [IDX_W-1:0]       slot_index;
  logic [GEN_FIELD_W-1:0] slot_generation;
  logic [LAYOUT_W-1:0]    layout_code;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [IDX_W-1:0]       result_index;
  logic [GEN_FIELD_W-1:0] result_generation;
  logic [VER_W-1:0]       result_version;
  logic [LAYOUT_W-1:0]    old_layout;
  logic                   layout_match;

  slot_table_scoreboard sb;
  slot_reply_t          seen_reply;
  int                   accepted;
  bit                   idle_on;

  generational_slot_allocator DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .slot_index       (slot_index),
    .slot_generation  (slot_generation),
    .layout_code      (layout_code),
    .done             (done),
    .status           (status),
    .result_index     (result_index),
    .result_generation(result_generation),
    .result_version   (result_version),
    .old_layout       (old_layout),
    .layout_match     (layout_match)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d replies outstanding", CYCLE_LIMIT, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // replies first, then the transaction taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen_reply.status       = status_t'(status);
        seen_reply.index        = result_index;
        seen_reply.generation   = result_generation;
        seen_reply.version      = result_version;
        seen_reply.old_layout   = old_layout;
        seen_reply.layout_match = layout_match;
        sb.check_reply(seen_reply, $time);
      end
      if (start && !busy) begin
        sb.note_request(op, slot_index, slot_generation, layout_code);
        accepted++;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(logic [OP_W-1:0] o, logic [IDX_W-1:0] idx,
                       logic [GEN_FIELD_W-1:0] gen, logic [LAYOUT_W-1:0] lay);
    int n;
    if (idle_on && $urandom_range(99) < 26) begin
      start           <= 1'b0;
      op              <= OP_W'($urandom);
      slot_index      <= IDX_W'($urandom);
      slot_generation <= GEN_FIELD_W'($urandom);
      layout_code     <= LAYOUT_W'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start           <= 1'b1;
    op              <= o;
    slot_index      <= idx;
    slot_generation <= gen;
    layout_code     <= lay;
    n = accepted;
    do @(negedge clk); while (accepted == n);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_item();
    int unsigned            pick;
    int unsigned            mode;
    int unsigned            idx;
    logic [OP_W-1:0]        o;
    logic [GEN_FIELD_W-1:0] gen;
    logic [LAYOUT_W-1:0]    lay;
    bit                     ok;
    pick = $urandom_range(99);
    if (pick < 18)      o = OP_CREATE;
    else if (pick < 38) o = OP_DESTROY;
    else if (pick < 52) o = OP_RECREATE;
    else if (pick < 64) o = OP_QUERY;
    else if (pick < 80) o = OP_TRANSITION;
    else if (pick < 97) o = OP_CHECK;
    else o = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
    lay  = LAYOUT_W'($urandom);
    mode = $urandom_range(99);
    ok   = 1'b0;
    if (mode < 75) ok = sb.pick_live(idx, gen);
    // stale handle: previous generation of a used slot
    if (!ok && mode < 88 && sb.slots_used > 0) begin
      idx = $urandom_range(sb.slots_used - 1);
      gen = sb.gen_store[idx] - 1'b1;
      ok  = 1'b1;
    end
    if (!ok) begin
      idx = $urandom_range(SLOTS - 1);
      gen = GEN_FIELD_W'($urandom);
    end
    if ((o == OP_CHECK || o == OP_QUERY) && sb.handle_live(idx, gen) && $urandom_range(1))
      lay = sb.layout_store[idx];
    issue(o, IDX_W'(idx), gen, lay);
  endtask

  task automatic fill_table();
    int unsigned            idx;
    logic [GEN_FIELD_W-1:0] gen;
    while (!(sb.slots_used == SLOTS && sb.free_count == 0))
      issue(OP_CREATE, IDX_W'($urandom), GEN_FIELD_W'($urandom), LAYOUT_W'($urandom));
    repeat (3) issue(OP_CREATE, IDX_W'($urandom), GEN_FIELD_W'($urandom), LAYOUT_W'($urandom));
    // invalid recreate on a full table acts as a create and reports full
    issue(OP_RECREATE, IDX_W'(SLOTS - 1), sb.gen_store[SLOTS - 1] + 16'd5, 4'hF);
    if (sb.pick_live(idx, gen)) issue(OP_RECREATE, IDX_W'(idx), gen, 4'h0);
  endtask

  initial begin
    int unsigned            slot;
    logic [GEN_FIELD_W-1:0] gen;
    sb              = new();
    accepted        = 0;
    idle_on         = 1'b1;
    rst             = 1'b1;
    start           = 1'b0;
    op              = OP_CREATE;
    slot_index      = '0;
    slot_generation = '0;
    layout_code     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed handle cases
    issue(OP_QUERY, 0, 16'h0000, 4'h0);         // nothing used yet
    issue(OP_DESTROY, 63, 16'hFFFF, 4'hF);
    issue(OP_UNDEF_LO, 5, 16'h1234, 4'h3);
    issue(OP_UNDEF_HI, 63, 16'hFFFF, 4'hF);
    issue(OP_CREATE, 0, 16'h0000, 4'h0);
    issue(OP_CREATE, 63, 16'hFFFF, 4'hF);
    issue(OP_QUERY, 0, 16'h0000, 4'h0);
    issue(OP_TRANSITION, 0, 16'h0000, 4'hF);
    issue(OP_CHECK, 0, 16'h0000, 4'hF);
    issue(OP_CHECK, 0, 16'h0000, 4'h0);
    issue(OP_QUERY, 0, 16'hFFFF, 4'hF);         // wrong generation
    issue(OP_RECREATE, 0, 16'h0000, 4'h7);      // valid: version goes to 2
    issue(OP_RECREATE, 0, 16'h0000, 4'h0);      // stale: plain create
    issue(OP_DESTROY, 1, 16'h0000, 4'h0);
    issue(OP_DESTROY, 1, 16'h0000, 4'h0);       // already destroyed
    issue(OP_CREATE, 0, 16'h0000, 4'h0);        // pops slot 1
    issue(OP_TRANSITION, 1, 16'h0001, 4'hA);
    issue(OP_QUERY, 1, 16'h0001, 4'hA);
    issue(OP_QUERY, 63, 16'h0000, 4'h0);        // index beyond used slots
    issue(OP_TRANSITION, 2, 16'h0000, 4'h5);
    issue(OP_CHECK, 2, 16'h0000, 4'h5);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) fill_table();
      if (i % 150 == 149) drain();
      random_item();
    end
    drain();

    // back-to-back recycling of one slot, no idle cycles
    idle_on = 1'b0;
    if (!sb.pick_live(slot, gen)) begin
      issue(OP_CREATE, 0, 16'h0000, 4'h0);
      void'(sb.pick_live(slot, gen));
    end
    repeat (RECYCLE_ROUNDS)
      issue(OP_RECREATE, IDX_W'(slot), sb.gen_store[slot], LAYOUT_W'($urandom));
    issue(OP_QUERY, IDX_W'(slot), sb.gen_store[slot], 4'h0);
    drain();
    repeat (8) @(negedge clk);

    $display("Covered %0d transactions: create %0d, destroy %0d, recreate %0d, query %0d,",
             accepted, sb.op_count[OP_CREATE], sb.op_count[OP_DESTROY],
             sb.op_count[OP_RECREATE], sb.op_count[OP_QUERY]);
    $display("  transition %0d, check %0d, undefined op %0d; %0d replies (%0d full, %0d invalid)",
             sb.op_count[OP_TRANSITION], sb.op_count[OP_CHECK],
             sb.op_count[OP_UNDEF_LO] + sb.op_count[OP_UNDEF_HI], sb.replies_checked,
             sb.full_seen, sb.invalid_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
